FILE: rtl/complex_fir_filter_q15_macros.svh
// Assertion macros shared by the complex FIR filter RTL.
`ifndef COMPLEX_FIR_FILTER_Q15_MACROS_SVH
`define COMPLEX_FIR_FILTER_Q15_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define CFQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define CFQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/cfq_pkg.sv
// Types and constants of the complex FIR filter.
`timescale 1ns / 1ps
`default_nettype none

package cfq_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int ACC_W        = 32;
    localparam int COEF_INDEX_W = 4;
    localparam int TAP_COUNT_W  = 5;
    localparam int RESULT_LSB   = 15;
    localparam int APB_DATA_W   = 32;
    localparam int APB_ADDR_W   = 3;

    localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RESET = 5'd16;

    // Item kinds
    typedef enum logic {
        KIND_SAMPLE = 1'b0,
        KIND_COEF   = 1'b1
    } cfq_kind_t;

    // Register indexes
    typedef enum logic {
        REG_TAP_COUNT = 1'b0,
        REG_UNUSED    = 1'b1
    } cfq_reg_t;

    // Beat passed from one tap cell to the next
    typedef struct packed {
        logic                           valid;
        cfq_kind_t                      kind;
        logic                           last;
        logic [COEF_INDEX_W-1:0]        coef_index;
        logic signed [SAMPLE_W-1:0]     coef_real;
        logic signed [SAMPLE_W-1:0]     coef_imag;
        logic signed [SAMPLE_W-1:0]     smp_real;
        logic signed [SAMPLE_W-1:0]     smp_imag;
        logic [ACC_W-1:0]               sum_real;
        logic [ACC_W-1:0]               sum_imag;
        logic [ACC_W-1:0]               prod_real;
        logic [ACC_W-1:0]               prod_imag;
    } cfq_beat_t;

endpackage

`default_nettype wire

FILE: rtl/cfq_cell.sv
// One tap cell: holds a coefficient and, except in tap 0, a history sample; multiplies, accumulates.
`timescale 1ns / 1ps
`default_nettype none

module cfq_cell #(
    parameter int TAP_INDEX = 0,
    parameter int LIMIT_W   = 5
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     advance,
    input  wire [LIMIT_W-1:0]       tap_limit,
    input  wire cfq_pkg::cfq_beat_t beat_in,
    output cfq_pkg::cfq_beat_t      beat_out
);

    logic signed [cfq_pkg::SAMPLE_W-1:0] coef_real_reg;
    logic signed [cfq_pkg::SAMPLE_W-1:0] coef_imag_reg;
    logic signed [cfq_pkg::SAMPLE_W-1:0] use_real;
    logic signed [cfq_pkg::SAMPLE_W-1:0] use_imag;
    logic signed [cfq_pkg::ACC_W-1:0]    mult_rr;
    logic signed [cfq_pkg::ACC_W-1:0]    mult_ii;
    logic signed [cfq_pkg::ACC_W-1:0]    mult_ri;
    logic signed [cfq_pkg::ACC_W-1:0]    mult_ir;
    logic                                tap_active;
    logic                                take_sample;
    logic                                take_coef;
    cfq_pkg::cfq_beat_t                  beat_reg;
    cfq_pkg::cfq_beat_t                  beat_next;

    assign take_sample = advance && beat_in.valid && (beat_in.kind == cfq_pkg::KIND_SAMPLE);
    assign take_coef   = advance && beat_in.valid && (beat_in.kind == cfq_pkg::KIND_COEF)
                         && (32'(beat_in.coef_index) == 32'(TAP_INDEX));
    assign tap_active  = LIMIT_W'(TAP_INDEX) < tap_limit;

    // Coefficient store of this tap
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_real_reg <= '0;
            coef_imag_reg <= '0;
        end
        else if (take_coef)
        begin
            coef_real_reg <= beat_in.coef_real;
            coef_imag_reg <= beat_in.coef_imag;
        end
    end

    // Sample seen by this tap; tap 0 sees the new sample itself
    generate
        if (TAP_INDEX == 0)
        begin : g_head
            assign use_real = beat_in.smp_real;
            assign use_imag = beat_in.smp_imag;
        end
        else
        begin : g_hist
            logic signed [cfq_pkg::SAMPLE_W-1:0] hist_real_reg;
            logic signed [cfq_pkg::SAMPLE_W-1:0] hist_imag_reg;

            // take the sample the previous tap used, hand the old one on
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    hist_real_reg <= '0;
                    hist_imag_reg <= '0;
                end
                else if (take_sample)
                begin
                    hist_real_reg <= beat_in.smp_real;
                    hist_imag_reg <= beat_in.smp_imag;
                end
            end

            assign use_real = hist_real_reg;
            assign use_imag = hist_imag_reg;
        end
    endgenerate

    // Complex product of this tap
    assign mult_rr = cfq_pkg::ACC_W'(coef_real_reg) * cfq_pkg::ACC_W'(use_real);
    assign mult_ii = cfq_pkg::ACC_W'(coef_imag_reg) * cfq_pkg::ACC_W'(use_imag);
    assign mult_ri = cfq_pkg::ACC_W'(coef_real_reg) * cfq_pkg::ACC_W'(use_imag);
    assign mult_ir = cfq_pkg::ACC_W'(coef_imag_reg) * cfq_pkg::ACC_W'(use_real);

    // Next beat: add the previous tap's product, register this one's
    always_comb
    begin
        beat_next           = beat_in;
        beat_next.smp_real  = use_real;
        beat_next.smp_imag  = use_imag;
        beat_next.sum_real  = beat_in.sum_real + beat_in.prod_real;
        beat_next.sum_imag  = beat_in.sum_imag + beat_in.prod_imag;
        if (tap_active)
        begin
            beat_next.prod_real = cfq_pkg::ACC_W'(mult_rr - mult_ii);
            beat_next.prod_imag = cfq_pkg::ACC_W'(mult_ri + mult_ir);
        end
        else
        begin
            beat_next.prod_real = '0;
            beat_next.prod_imag = '0;
        end
    end

    // Beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            beat_reg <= '0;
        else if (advance)
            beat_reg <= beat_next;
    end

    assign beat_out = beat_reg;

endmodule

`default_nettype wire

FILE: rtl/complex_fir_filter_q15.sv
// Complex FIR filter with Q15 taps: input port, tap cell chain, result register, config.
//
// Usage:
//   Input channel (sample_valid / sample_stall): each beat is either a complex sample
//   (kind = 0) or a coefficient write (kind = 1) to tap coef_index.
//   Result channel (result_valid / result_stall): one beat per sample, carrying
//   out_real / out_imag = accumulator bits 30..15 and last_out = last_in.
//   Coefficient beats give no result.
//   Path: a sample's beat passes through each tap cell's beat register in turn,
//   then through the result register before the result is offered.
//   Throughput: one beat per cycle unless stalled; each cell works on a different beat.
//   Stall: while a result is held by result_stall the whole chain freezes and
//   sample_stall is raised; nothing is lost or repeated.
//   Reset: history and coefficients cleared, tap_count = 16, no result pending.
//   tap_count (APB register 0, byte address 0): the user must write it only while idle
//   (the block does not enforce this); zero acts as one tap, above MAX_TAPS as MAX_TAPS.
`timescale 1ns / 1ps
`default_nettype none

module complex_fir_filter_q15 #(
    parameter int MAX_TAPS = 16
) (
    input  wire                                    clk,
    input  wire                                    rst_n,
    // sample channel
    input  wire                                    sample_valid,
    output logic                                   sample_stall,
    input  wire  [0:0]                             kind,
    input  wire  signed [cfq_pkg::SAMPLE_W-1:0]    in_real,
    input  wire  signed [cfq_pkg::SAMPLE_W-1:0]    in_imag,
    input  wire  [cfq_pkg::COEF_INDEX_W-1:0]       coef_index,
    input  wire  signed [cfq_pkg::SAMPLE_W-1:0]    coef_real,
    input  wire  signed [cfq_pkg::SAMPLE_W-1:0]    coef_imag,
    input  wire                                    last_in,
    // result channel
    output logic                                   result_valid,
    input  wire                                    result_stall,
    output logic signed [cfq_pkg::SAMPLE_W-1:0]    out_real,
    output logic signed [cfq_pkg::SAMPLE_W-1:0]    out_imag,
    output logic                                   last_out,
    // config port
    input  wire                                    psel,
    input  wire                                    penable,
    input  wire                                    pwrite,
    input  wire  [cfq_pkg::APB_ADDR_W-1:0]         paddr,
    input  wire  [cfq_pkg::APB_DATA_W-1:0]         pwdata,
    output logic [cfq_pkg::APB_DATA_W-1:0]         prdata,
    output logic                                   pready
);

`include "complex_fir_filter_q15_macros.svh"

    localparam int LIMIT_W = $clog2(MAX_TAPS + 1);

    logic [cfq_pkg::TAP_COUNT_W-1:0]          tap_count_reg;
    logic [LIMIT_W-1:0]                       tap_limit;
    cfq_pkg::cfq_reg_t                        reg_index;
    logic                                     advance;
    cfq_pkg::cfq_beat_t                       head_beat;
    cfq_pkg::cfq_beat_t                       chain [MAX_TAPS];
    cfq_pkg::cfq_beat_t                       tail;
    logic [cfq_pkg::ACC_W-1:0]                acc_real;
    logic [cfq_pkg::ACC_W-1:0]                acc_imag;
    logic                                     result_valid_reg;
    logic                                     result_valid_next;
    logic signed [cfq_pkg::SAMPLE_W-1:0]      out_real_reg;
    logic signed [cfq_pkg::SAMPLE_W-1:0]      out_imag_reg;
    logic                                     last_out_reg;
    logic                                     tail_coef;
    logic                                     tap_limit_ok;

    // Config register
    assign pready    = 1'b1;
    assign reg_index = cfq_pkg::cfq_reg_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tap_count_reg <= cfq_pkg::TAP_COUNT_RESET;
        else if (psel && penable && pwrite && pready && (reg_index == cfq_pkg::REG_TAP_COUNT))
            tap_count_reg <= pwdata[cfq_pkg::TAP_COUNT_W-1:0];
    end

    always_comb
    begin
        unique case (reg_index)
            cfq_pkg::REG_TAP_COUNT:
                prdata = cfq_pkg::APB_DATA_W'(tap_count_reg);
            default:
                prdata = '0;
        endcase
    end

    // Effective number of taps
    always_comb
    begin
        if (tap_count_reg == '0)
            tap_limit = LIMIT_W'(1);
        else if (32'(tap_count_reg) > 32'(MAX_TAPS))
            tap_limit = LIMIT_W'(MAX_TAPS);
        else
            tap_limit = LIMIT_W'(tap_count_reg);
    end

    // Chain moves whenever the result register can take a beat
    assign advance      = !result_valid_reg || !result_stall;
    assign sample_stall = !advance;

    // Beat entering the first cell
    always_comb
    begin
        head_beat            = '0;
        head_beat.valid      = sample_valid;
        head_beat.kind       = cfq_pkg::cfq_kind_t'(kind);
        head_beat.last       = last_in;
        head_beat.coef_index = coef_index;
        head_beat.coef_real  = coef_real;
        head_beat.coef_imag  = coef_imag;
        head_beat.smp_real   = in_real;
        head_beat.smp_imag   = in_imag;
    end

    // Tap cell chain
    generate
        for (genvar i = 0; i < MAX_TAPS; i++)
        begin : g_cell
            cfq_cell #(
                .TAP_INDEX (i),
                .LIMIT_W   (LIMIT_W)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .advance   (advance),
                .tap_limit (tap_limit),
                .beat_in   ((i == 0) ? head_beat : chain[(i == 0) ? 0 : i - 1]),
                .beat_out  (chain[i])
            );
        end
    endgenerate

    assign tail     = chain[MAX_TAPS-1];
    assign acc_real = tail.sum_real + tail.prod_real;
    assign acc_imag = tail.sum_imag + tail.prod_imag;

    // Result register
    assign result_valid_next = tail.valid && (tail.kind == cfq_pkg::KIND_SAMPLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (advance)
            result_valid_reg <= result_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_real_reg <= acc_real[cfq_pkg::RESULT_LSB +: cfq_pkg::SAMPLE_W];
            out_imag_reg <= acc_imag[cfq_pkg::RESULT_LSB +: cfq_pkg::SAMPLE_W];
            last_out_reg <= tail.last;
        end
    end

    assign result_valid = result_valid_reg;
    assign out_real     = out_real_reg;
    assign out_imag     = out_imag_reg;
    assign last_out     = last_out_reg;

    // Checks
    assign tail_coef    = tail.valid && (tail.kind == cfq_pkg::KIND_COEF);
    assign tap_limit_ok = (tap_limit != '0) && (32'(tap_limit) <= 32'(MAX_TAPS));

    `CFQ_ASSERT_NEXT(a_coef_no_result, advance && tail_coef, !result_valid, "coef beat gave result")
    `CFQ_ASSERT_NEXT(a_sample_result, advance && result_valid_next, result_valid, "sample beat lost")
    `CFQ_ASSERT_NOW(a_stall_full, sample_stall, result_valid && result_stall, "stall, no held beat")
    `CFQ_ASSERT_NOW(a_tap_limit, 1'b1, tap_limit_ok, "tap limit out of range")

endmodule

`default_nettype wire
